>>> sv/smt_pkg.sv
// Package for the small set membership table: sizes, operation codes,
// status codes and the command and status structs between the modules.
// Depends on nothing.
`timescale 1ns / 1ps

package smt_pkg;

  localparam int CAPACITY  = 16;
  localparam int ELEM_W    = 32;
  localparam int COUNT_W   = 5;
  localparam int CNT_W     = $clog2(CAPACITY + 1);
  localparam int IDX_W     = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  typedef enum logic [1:0] {
    OP_INSERT = 2'd0,
    OP_DELETE = 2'd1,
    OP_QUERY  = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_CHANGED  = 2'd0,
    ST_NOCHANGE = 2'd1,
    ST_REJECTED = 2'd2
  } status_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;    // capture the accepted operation
    logic commit;  // look up, update the table and load the result
  } cmd_t;

  // Status from the datapath.
  typedef struct packed {
    logic [CNT_W-1:0] count;
  } sts_t;

endpackage

>>> sv/smt_if.sv
// Channel interfaces of the small set membership table: the operation
// channel and the result channel, each with valid, ready and payload.
// Depends on smt_pkg.
`timescale 1ns / 1ps

interface smt_in_if;
  logic                                valid;
  logic                                ready;
  logic [1:0]                          kind;
  logic signed [smt_pkg::ELEM_W-1:0]   element;

  modport source (output valid, output kind, output element, input ready);
  modport sink   (input valid, input kind, input element, output ready);
endinterface

interface smt_out_if;
  logic                          valid;
  logic                          ready;
  logic                          found;
  logic [smt_pkg::COUNT_W-1:0]   count;
  logic                          is_empty;
  logic                          is_full;
  logic [1:0]                    status;

  modport source (output valid, output found, output count, output is_empty,
                  output is_full, output status, input ready);
  modport sink   (input valid, input found, input count, input is_empty,
                  input is_full, input status, output ready);
endinterface

>>> sv/smt_ctrl.sv
// Controller of the small set membership table: sequences each operation
// and owns the handshakes. Depends on smt_pkg.
`timescale 1ns / 1ps

module smt_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  output smt_pkg::cmd_t cmd
);

  typedef enum logic {
    S_IDLE,
    S_EXEC
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;

  assign in_ready   = (state_r == S_IDLE);
  assign out_free   = !out_valid_r || out_ready;
  assign cmd.load   = in_valid && in_ready;
  assign cmd.commit = (state_r == S_EXEC) && out_free;
  assign out_valid  = out_valid_r;

  always_comb begin
    state_nxt     = state_r;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_IDLE: begin
        if (cmd.load) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        // The result waits here until the output register is free.
        if (out_free) begin
          state_nxt     = S_IDLE;
          out_valid_nxt = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

>>> sv/smt_dp.sv
// Datapath of the small set membership table: the packed entry table,
// the member count, the parallel compare and the result register.
// Depends on smt_pkg.
`timescale 1ns / 1ps

module smt_dp (
  input  logic                              clk,
  input  logic                              rst_n,
  input  smt_pkg::cmd_t                     cmd,
  input  logic [1:0]                        in_kind,
  input  logic signed [smt_pkg::ELEM_W-1:0] in_element,
  output logic                              res_found,
  output logic [smt_pkg::COUNT_W-1:0]       res_count,
  output logic                              res_is_empty,
  output logic                              res_is_full,
  output logic [1:0]                        res_status,
  output smt_pkg::sts_t                     sts
);

  logic signed [smt_pkg::ELEM_W-1:0] entry_r [smt_pkg::CAPACITY];
  logic [smt_pkg::CNT_W-1:0]         count_r, count_nxt;
  smt_pkg::op_t                      kind_r;
  logic signed [smt_pkg::ELEM_W-1:0] element_r;

  logic [smt_pkg::CAPACITY-1:0]      match;
  logic [smt_pkg::IDX_W-1:0]         slot;
  logic                              found;
  logic                              do_insert;
  logic                              do_delete;
  smt_pkg::status_t                  status;

  logic                              found_r;
  logic [smt_pkg::COUNT_W-1:0]       res_count_r;
  logic                              is_empty_r;
  logic                              is_full_r;
  smt_pkg::status_t                  status_r;

  // Only occupied slots take part; members are distinct, so at most one
  // slot matches and its index is the OR of the matching indices.
  always_comb begin
    slot = '0;
    for (int j = 0; j < smt_pkg::CAPACITY; j++) begin
      match[j] = (smt_pkg::CNT_W'(j) < count_r) && (entry_r[j] == element_r);
      if (match[j]) begin
        slot = slot | smt_pkg::IDX_W'(j);
      end
    end
  end

  assign found = |match;

  always_comb begin
    count_nxt = count_r;
    do_insert = 1'b0;
    do_delete = 1'b0;
    status    = smt_pkg::ST_NOCHANGE;
    case (kind_r)
      smt_pkg::OP_INSERT: begin
        if (found) begin
          status = smt_pkg::ST_NOCHANGE;
        end else if (count_r >= smt_pkg::CNT_W'(smt_pkg::CAPACITY)) begin
          status = smt_pkg::ST_REJECTED;
        end else begin
          do_insert = 1'b1;
          count_nxt = count_r + smt_pkg::CNT_W'(1);
          status    = smt_pkg::ST_CHANGED;
        end
      end
      smt_pkg::OP_DELETE: begin
        if (found) begin
          do_delete = 1'b1;
          count_nxt = count_r - smt_pkg::CNT_W'(1);
          status    = smt_pkg::ST_CHANGED;
        end
      end
      smt_pkg::OP_QUERY: begin
        status = smt_pkg::ST_NOCHANGE;
      end
      default: begin
        status    = (count_r != '0) ? smt_pkg::ST_CHANGED : smt_pkg::ST_NOCHANGE;
        count_nxt = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (cmd.commit) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      kind_r    <= smt_pkg::op_t'(in_kind);
      element_r <= in_element;
    end
  end

  // Table update: an insert appends at the count; a delete moves every
  // occupied slot above the removed one down by one place.
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      for (int j = 0; j < smt_pkg::CAPACITY; j++) begin
        if (do_insert && (count_r[smt_pkg::IDX_W-1:0] == smt_pkg::IDX_W'(j))) begin
          entry_r[j] <= element_r;
        end else if (do_delete && (j + 1 < smt_pkg::CAPACITY) &&
                     (smt_pkg::IDX_W'(j) >= slot) &&
                     (smt_pkg::CNT_W'(j + 1) < count_r)) begin
          entry_r[j] <= entry_r[(j + 1) % smt_pkg::CAPACITY];
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      found_r     <= found;
      res_count_r <= smt_pkg::COUNT_W'(count_nxt);
      is_empty_r  <= (count_nxt == '0);
      is_full_r   <= (count_nxt == smt_pkg::CNT_W'(smt_pkg::CAPACITY));
      status_r    <= status;
    end
  end

  assign res_found    = found_r;
  assign res_count    = res_count_r;
  assign res_is_empty = is_empty_r;
  assign res_is_full  = is_full_r;
  assign res_status   = status_r;
  assign sts.count    = count_r;

endmodule

>>> sv/small_set_membership_table.sv
// Small set membership table: keeps up to CAPACITY distinct 32-bit values
// in a packed table and answers insert, delete, query and clear operations.
//
// Channels: in_if carries one operation (kind, element) per transfer;
// out_if carries one result (found, count, is_empty, is_full, status) for
// every operation, in order. Both use valid/ready; a transfer happens on a
// rising edge with valid and ready high.
//
// Timing: an operation is captured at its transfer and executed in the EXEC
// state, where the sixteen slots are compared in parallel and the table is
// updated. The result becomes valid and in_if.ready returns at the end of that
// state, so the block takes no new operation until the last has executed.
//
// Stall: a result waits in the output register while out_if.ready is low; the
// next operation is still accepted, and its execution holds until that is free.
//
// Reset: synchronous, active low. It empties the set and drops any pending
// result; table slots are not cleared, as only occupied slots are read.
// Depends on smt_pkg, smt_if, smt_ctrl and smt_dp.
`timescale 1ns / 1ps

module small_set_membership_table (
  input  logic          clk,
  input  logic          rst_n,
  smt_in_if.sink        in_if,
  smt_out_if.source     out_if
);

  smt_pkg::cmd_t cmd;
  smt_pkg::sts_t sts;

  smt_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_if.valid),
    .in_ready  (in_if.ready),
    .out_valid (out_if.valid),
    .out_ready (out_if.ready),
    .cmd       (cmd)
  );

  smt_dp u_dp (
    .clk          (clk),
    .rst_n        (rst_n),
    .cmd          (cmd),
    .in_kind      (in_if.kind),
    .in_element   (in_if.element),
    .res_found    (out_if.found),
    .res_count    (out_if.count),
    .res_is_empty (out_if.is_empty),
    .res_is_full  (out_if.is_full),
    .res_status   (out_if.status),
    .sts          (sts)
  );

`ifndef NO_ASSERTIONS
  // The member count never exceeds the capacity.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sts.count <= smt_pkg::CNT_W'(smt_pkg::CAPACITY))
    else $error("member count above capacity");

  // An execution never overwrites a result that is still waiting.
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |-> (!out_if.valid || out_if.ready))
    else $error("result overwritten while stalled");

  // Every execution presents a result in the following cycle.
  a_commit_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_if.valid)
    else $error("execution gave no result");

  // An accepted operation blocks the input until it has executed.
  a_busy_after_load: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |=> !in_if.ready)
    else $error("input ready while an operation is pending");
`endif

endmodule

>>> tb/sv/tb.sv
// Self-checking bench for the small set membership table: drives operations
// over the input channel and checks every result against a local set model.
// Depends on smt_pkg, smt_if and small_set_membership_table.
`timescale 1ns / 1ps

module tb;

  // An operation waiting to be offered. When drain_first is set the sender
  // holds it back until every outstanding result has been collected.
  typedef struct packed {
    smt_pkg::op_t               kind;
    logic [smt_pkg::ELEM_W-1:0] element;
    bit                         drain_first;
  } set_op_t;

  // One predicted result, laid out as the result channel carries it.
  typedef struct packed {
    logic                        found;
    logic [smt_pkg::COUNT_W-1:0] count;
    logic                        is_empty;
    logic                        is_full;
    smt_pkg::status_t            status;
  } set_answer_t;

  localparam int POOL_SIZE      = 24;   // more than CAPACITY, so the set fills up
  localparam int RANDOM_BLOCKS  = 46;
  localparam int BLOCK_LEN      = 40;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int SETTLE_CYCLES  = 20;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  smt_in_if  in_ch ();
  smt_out_if out_ch ();

  small_set_membership_table u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_ch),
    .out_if (out_ch)
  );

  always #5 clk = ~clk;

  // Operations still to be offered, and results still to be collected.
  set_op_t     pending_op_q [$];
  set_answer_t expected_answer_q [$];

  // Local copy of the set: packed members in slots below member_total.
  logic [smt_pkg::ELEM_W-1:0] model_slots [smt_pkg::CAPACITY];
  int                         member_total = 0;

  logic [smt_pkg::ELEM_W-1:0] value_pool [POOL_SIZE];

  int mismatch_count = 0;
  int burst_left     = 1;
  int gap_left       = 0;
  int idle_cycles    = 0;
  logic [8:0] ready_phase = '0;

  // Every input of the block is known from time zero onwards.
  initial begin
    in_ch.valid   = 1'b0;
    in_ch.kind    = smt_pkg::OP_QUERY;
    in_ch.element = '0;
    out_ch.ready  = 1'b0;
  end

  // Applies one operation to the local set and returns the result it owes.
  // Delete closes the gap by moving only the occupied slots above the hit.
  function automatic set_answer_t apply_set_op(smt_pkg::op_t kind,
                                               logic [smt_pkg::ELEM_W-1:0] element);
    int          hit;
    set_answer_t ans;
    hit = -1;
    for (int i = 0; i < member_total; i++)
      if (hit < 0 && model_slots[i] == element) hit = i;
    ans.found  = (hit >= 0);
    ans.status = smt_pkg::ST_NOCHANGE;
    case (kind)
      smt_pkg::OP_INSERT: begin
        if (hit < 0) begin
          if (member_total >= smt_pkg::CAPACITY) begin
            ans.status = smt_pkg::ST_REJECTED;
          end else begin
            model_slots[member_total] = element;
            member_total++;
            ans.status = smt_pkg::ST_CHANGED;
          end
        end
      end
      smt_pkg::OP_DELETE: begin
        if (hit >= 0) begin
          for (int j = hit; j < member_total - 1; j++)
            model_slots[j] = model_slots[j + 1];
          member_total--;
          ans.status = smt_pkg::ST_CHANGED;
        end
      end
      smt_pkg::OP_QUERY: begin
        ans.status = smt_pkg::ST_NOCHANGE;
      end
      default: begin
        // Clear reports a change only if there was something to remove.
        if (member_total != 0) ans.status = smt_pkg::ST_CHANGED;
        member_total = 0;
      end
    endcase
    ans.count    = smt_pkg::COUNT_W'(member_total);
    ans.is_empty = (member_total == 0);
    ans.is_full  = (member_total == smt_pkg::CAPACITY);
    return ans;
  endfunction

  task automatic queue_op(input smt_pkg::op_t kind,
                          input logic [smt_pkg::ELEM_W-1:0] element,
                          input bit drain_first);
    set_op_t op;
    op.kind        = kind;
    op.element     = element;
    op.drain_first = drain_first;
    pending_op_q.push_back(op);
  endtask

  // Sender. It offers operations in bursts of random length separated by
  // random gaps. Once valid is raised it stays high until the transfer, and
  // the expected result is predicted at the edge of that transfer.
  always @(posedge clk) begin : drive_ops
    logic offer;
    offer = in_ch.valid;
    if (!rst_n) begin
      offer = 1'b0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        expected_answer_q.push_back(apply_set_op(smt_pkg::op_t'(in_ch.kind),
                                                 in_ch.element));
        void'(pending_op_q.pop_front());
        offer = 1'b0;
        burst_left--;
        if (burst_left <= 0) begin
          gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
          burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                   : $urandom_range(1, 16);
        end
      end
      if (!offer) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_op_q.size() != 0 &&
                     !(pending_op_q[0].drain_first && expected_answer_q.size() != 0)) begin
          offer = 1'b1;
          in_ch.kind    <= pending_op_q[0].kind;
          in_ch.element <= pending_op_q[0].element;
        end
      end
    end
    in_ch.valid <= offer;
  end

  // Receiver. The ready pattern cycles through four moods in turn:
  // always ready, coin-toss, mostly ready, and long regular stalls.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      ready_phase  <= '0;
    end else begin
      ready_phase <= ready_phase + 9'd1;
      case (ready_phase[8:7])
        2'd0:    out_ch.ready <= 1'b1;
        2'd1:    out_ch.ready <= ($urandom_range(0, 1) == 1);
        2'd2:    out_ch.ready <= ($urandom_range(0, 3) != 0);
        default: out_ch.ready <= (ready_phase[4:0] >= 5'd20);
      endcase
    end
  end

  // Monitor. Each result transfer is matched against the oldest prediction;
  // a result that arrives with nothing predicted is a failure as well.
  always @(posedge clk) begin : check_results
    set_answer_t exp;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_answer_q.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("[%0t] Unexpected result: found=%0b count=%0d empty=%0b full=%0b status=%0d",
                   $realtime, out_ch.found, out_ch.count, out_ch.is_empty, out_ch.is_full,
                   out_ch.status);
      end else begin
        exp = expected_answer_q.pop_front();
        if (out_ch.found !== exp.found || out_ch.count !== exp.count ||
            out_ch.is_empty !== exp.is_empty || out_ch.is_full !== exp.is_full ||
            out_ch.status !== exp.status) begin
          mismatch_count++;
          if (mismatch_count <= 10) begin
            $display("[%0t] Result mismatch: expected found=%0b count=%0d empty=%0b full=%0b status=%0d",
                     $realtime, exp.found, exp.count, exp.is_empty, exp.is_full, exp.status);
            $display("         got found=%0b count=%0d empty=%0b full=%0b status=%0d",
                     out_ch.found, out_ch.count, out_ch.is_empty, out_ch.is_full,
                     out_ch.status);
          end
        end
      end
    end
  end

  // Watchdog: a long stretch with no transfer on either channel means the
  // block has hung.
  always @(posedge clk) begin
    if (!rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Stimulus and end of run.
  initial begin : stimulus
    int                         mode;
    int                         roll;
    smt_pkg::op_t               kind;
    logic [smt_pkg::ELEM_W-1:0] element;

    // Directed part. An empty set first: query, delete and clear all find
    // nothing to do.
    queue_op(smt_pkg::OP_QUERY,  32'h0000_0005, 1'b0);
    queue_op(smt_pkg::OP_DELETE, 32'h0000_0005, 1'b0);
    queue_op(smt_pkg::OP_CLEAR,  32'h0000_0005, 1'b0);
    // Extreme values, then a repeated insert and a delete from the middle.
    queue_op(smt_pkg::OP_INSERT, 32'h8000_0000, 1'b0);
    queue_op(smt_pkg::OP_INSERT, 32'h7FFF_FFFF, 1'b0);
    queue_op(smt_pkg::OP_INSERT, 32'h0000_0000, 1'b0);
    queue_op(smt_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0);
    queue_op(smt_pkg::OP_INSERT, 32'h0000_0000, 1'b0);
    queue_op(smt_pkg::OP_DELETE, 32'h7FFF_FFFF, 1'b0);
    // Fill the set to capacity.
    for (int k = 1; k <= smt_pkg::CAPACITY - 3; k++)
      queue_op(smt_pkg::OP_INSERT, smt_pkg::ELEM_W'(k), 1'b0);
    // A new value is turned away when full; a present one is not an error.
    queue_op(smt_pkg::OP_INSERT, 32'h1234_5678, 1'b0);
    queue_op(smt_pkg::OP_INSERT, 32'hFFFF_FFFF, 1'b0);
    // Remove the last and the first slot, then clear with a member named.
    queue_op(smt_pkg::OP_DELETE, smt_pkg::ELEM_W'(smt_pkg::CAPACITY - 3), 1'b0);
    queue_op(smt_pkg::OP_DELETE, 32'h8000_0000, 1'b0);
    queue_op(smt_pkg::OP_CLEAR,  32'hFFFF_FFFF, 1'b0);
    queue_op(smt_pkg::OP_QUERY,  32'hFFFF_FFFF, 1'b0);

    // Random part. Elements mostly come from a small pool so that members
    // are hit often; the pool holds the extremes and neighbours one bit
    // apart. Each block leans towards filling, draining or a mix.
    value_pool[0] = 32'h0000_0000;
    value_pool[1] = 32'hFFFF_FFFF;
    value_pool[2] = 32'h8000_0000;
    value_pool[3] = 32'h7FFF_FFFF;
    for (int blk = 0; blk < RANDOM_BLOCKS; blk++) begin
      if (blk % 8 == 0) begin
        for (int i = 4; i < POOL_SIZE; i++)
          value_pool[i] = (i % 2 == 1) ? smt_pkg::ELEM_W'($urandom())
                                       : value_pool[i - 1] ^ (32'h1 << $urandom_range(0, 31));
      end
      mode = $urandom_range(0, 2);
      for (int n = 0; n < BLOCK_LEN; n++) begin
        roll = $urandom_range(0, 99);
        case (mode)
          0:       kind = (roll < 60) ? smt_pkg::OP_INSERT :
                          (roll < 75) ? smt_pkg::OP_DELETE :
                          (roll < 98) ? smt_pkg::OP_QUERY : smt_pkg::OP_CLEAR;
          1:       kind = (roll < 20) ? smt_pkg::OP_INSERT :
                          (roll < 75) ? smt_pkg::OP_DELETE :
                          (roll < 98) ? smt_pkg::OP_QUERY : smt_pkg::OP_CLEAR;
          default: kind = (roll < 38) ? smt_pkg::OP_INSERT :
                          (roll < 68) ? smt_pkg::OP_DELETE :
                          (roll < 98) ? smt_pkg::OP_QUERY : smt_pkg::OP_CLEAR;
        endcase
        element = ($urandom_range(0, 99) < 85) ? value_pool[$urandom_range(0, POOL_SIZE - 1)]
                                               : smt_pkg::ELEM_W'($urandom());
        // Now and then the sender waits for the result channel to run dry.
        queue_op(kind, element, (blk == 0 && n == 0) || ($urandom_range(0, 149) == 0));
      end
    end

    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    while (pending_op_q.size() != 0 || in_ch.valid) @(posedge clk);
    while (expected_answer_q.size() != 0) @(posedge clk);
    // Keep running after the last result so that any stray one would still be caught.
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
